### design/w_projection_phase_screen_defines.svh
// Assertion macros shared by the phase screen checker.
// Depends on nothing; include by bare file name.
`ifndef W_PROJECTION_PHASE_SCREEN_DEFINES_SVH
`define W_PROJECTION_PHASE_SCREEN_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WPPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WPPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Check that does not depend on reset being low.
`define WPPS_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

### design/wpps_pkg.sv
// Package for the W-projection phase screen: register indexes, widths,
// CORDIC and square root constants. Depends on nothing.
package wpps_pkg;

   localparam int INDEX_W      = 12;
   localparam int TAPER_W      = 16;
   localparam int SAMPLE_W     = 16;
   localparam int REG_W        = 32;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_STEP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_TURNS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_SIZE   = 2'd2;

   localparam logic [INDEX_W-1:0] HALF_SIZE_RESET = 12'd2048;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 18;
   localparam int CORDIC_W     = 32;
   localparam int ANGLE_W      = 25;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

   // arctan(2^-i) in units of 2^-24 turn
   function automatic logic [21:0] atan_entry(input int idx);
      logic [21:0] val;
      case (idx)
         0:       val = 22'd2097152;
         1:       val = 22'd1238021;
         2:       val = 22'd654136;
         3:       val = 22'd332050;
         4:       val = 22'd166669;
         5:       val = 22'd83416;
         6:       val = 22'd41718;
         7:       val = 22'd20860;
         8:       val = 22'd10430;
         9:       val = 22'd5215;
         10:      val = 22'd2608;
         11:      val = 22'd1304;
         12:      val = 22'd652;
         13:      val = 22'd326;
         14:      val = 22'd163;
         15:      val = 22'd81;
         16:      val = 22'd41;
         17:      val = 22'd20;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

### design/w_projection_phase_screen.sv
// W-projection phase screen: one pixel in, one Q1.15 complex sample out.
// Throughput one transaction per cycle while no stalled result holds the
// output register, set by the 32-stage square root and 18-stage CORDIC
// pipelines, which each retire one bit or one rotation per stage.
// Synchronous active-high reset clears the valid bits and loads the
// registers with pixel_step 0, phase_turns 0, half_size 2048.
module w_projection_phase_screen
   import wpps_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [REG_W-1:0]             csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [INDEX_W-1:0]           req_col_index,
   input  logic [INDEX_W-1:0]           req_row_index,
   input  logic [TAPER_W-1:0]           req_taper_col,
   input  logic [TAPER_W-1:0]           req_taper_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_real_part,
   output logic signed [SAMPLE_W-1:0]   rsp_imag_part,
   output logic                         rsp_inside_res
);

   localparam int PIPE_DEPTH = 4 + SQRT_STEPS + 3 + CORDIC_STEPS + 3;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [REG_W-1:0]   pixel_step_ff;
   logic [REG_W-1:0]   phase_turns_ff;
   logic [INDEX_W-1:0] half_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_step_ff  <= '0;
         phase_turns_ff <= '0;
         half_size_ff   <= HALF_SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PIXEL_STEP:  pixel_step_ff  <= csr_data;
            REG_PHASE_TURNS: phase_turns_ff <= csr_data;
            REG_HALF_SIZE:   half_size_ff   <= csr_data[INDEX_W-1:0];
            default:         ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: every stage advances together unless the
   // finished transaction in the output register is stalled.
   // ---------------------------------------------------------------
   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign adv       = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: centred offsets (absolute) and taper product
   // ---------------------------------------------------------------
   logic signed [INDEX_W:0] dc_in, dr_in;
   logic [INDEX_W-1:0]      absc_ff, absr_ff;
   logic [2*TAPER_W-1:0]    w1_ff;

   assign dc_in = $signed({1'b0, req_col_index}) - $signed({1'b0, half_size_ff});
   assign dr_in = $signed({1'b0, req_row_index}) - $signed({1'b0, half_size_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         absc_ff <= dc_in[INDEX_W] ? INDEX_W'(-dc_in) : dc_in[INDEX_W-1:0];
         absr_ff <= dr_in[INDEX_W] ? INDEX_W'(-dr_in) : dr_in[INDEX_W-1:0];
         w1_ff   <= req_taper_col * req_taper_row;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: direction cosines l and m (Q12.32, may exceed 1)
   // ---------------------------------------------------------------
   logic [INDEX_W+REG_W-1:0] l_ff, m_ff;
   logic [2*TAPER_W-1:0]     w2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff  <= absc_ff * pixel_step_ff;
         m_ff  <= absr_ff * pixel_step_ff;
         w2_ff <= w1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: squares, keep the Q0.32 part
   // ---------------------------------------------------------------
   logic [2*REG_W-1:0] l2_in, m2_in;
   logic [REG_W-1:0]   l2_ff, m2_ff;
   logic               in3_ff;
   logic [2*TAPER_W-1:0] w3_ff;

   assign l2_in = l_ff[REG_W-1:0] * l_ff[REG_W-1:0];
   assign m2_in = m_ff[REG_W-1:0] * m_ff[REG_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         l2_ff  <= l2_in[2*REG_W-1:REG_W];
         m2_ff  <= m2_in[2*REG_W-1:REG_W];
         in3_ff <= (l_ff[INDEX_W+REG_W-1:REG_W] == '0) &&
                   (m_ff[INDEX_W+REG_W-1:REG_W] == '0);
         w3_ff  <= w2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: r2 and s = 1 - r2, feeding the square root pipeline
   // ---------------------------------------------------------------
   logic [REG_W:0] r2_in, s_in;

   logic [REG_W-1:0]     sq_s_ff    [0:SQRT_STEPS];
   logic [REG_W:0]       sq_rem_ff  [0:SQRT_STEPS];
   logic [REG_W-1:0]     sq_root_ff [0:SQRT_STEPS];
   logic                 sq_one_ff  [0:SQRT_STEPS];
   logic                 sq_in_ff   [0:SQRT_STEPS];
   logic [2*TAPER_W-1:0] sq_w_ff    [0:SQRT_STEPS];

   assign r2_in = {1'b0, l2_ff} + {1'b0, m2_ff};
   assign s_in  = {1'b1, {REG_W{1'b0}}} - r2_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_s_ff[0]    <= s_in[REG_W-1:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_one_ff[0]  <= (r2_in == '0);
         sq_in_ff[0]   <= in3_ff && !r2_in[REG_W];
         sq_w_ff[0]    <= w3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Square root of s * 2^32, one result bit per stage. The low half
   // of the radicand is zero, so the upper iterations take bit pairs
   // of s and the lower ones take zeros.
   // ---------------------------------------------------------------
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int BIT_IDX = SQRT_STEPS - 1 - k;
      logic [1:0]       pair;
      logic [REG_W+2:0] rem_sh, trial, diff;

      if (BIT_IDX >= SQRT_STEPS / 2) begin : g_hi
         assign pair = sq_s_ff[k][2*(BIT_IDX-SQRT_STEPS/2)+1 -: 2];
      end else begin : g_lo
         assign pair = 2'b00;
      end

      assign rem_sh = {sq_rem_ff[k], pair};
      assign trial  = {1'b0, sq_root_ff[k], 2'b01};
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_sh >= trial) begin
               sq_rem_ff[k+1]  <= diff[REG_W:0];
               sq_root_ff[k+1] <= {sq_root_ff[k][REG_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[k+1]  <= rem_sh[REG_W:0];
               sq_root_ff[k+1] <= {sq_root_ff[k][REG_W-2:0], 1'b0};
            end
            sq_s_ff[k+1]   <= sq_s_ff[k];
            sq_one_ff[k+1] <= sq_one_ff[k];
            sq_in_ff[k+1]  <= sq_in_ff[k];
            sq_w_ff[k+1]   <= sq_w_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // t = 1 - sqrt(s). When s is exactly one, t is zero; otherwise the
   // root is nonzero and t fits in 32 bits.
   // ---------------------------------------------------------------
   logic [REG_W-1:0]     t_ff;
   logic                 t_in_ff;
   logic [2*TAPER_W-1:0] t_w_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= sq_one_ff[SQRT_STEPS] ? '0 : REG_W'(0) - sq_root_ff[SQRT_STEPS];
         t_in_ff <= sq_in_ff[SQRT_STEPS];
         t_w_ff  <= sq_w_ff[SQRT_STEPS];
      end
   end

   // Phase product; only the low 48 bits reach the angle.
   logic [2*REG_W-1:0]   p_in;
   logic [47:0]          p_ff;
   logic                 p_in_ff;
   logic [2*TAPER_W-1:0] p_w_ff;

   assign p_in = phase_turns_ff * t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in[47:0];
         p_in_ff <= t_in_ff;
         p_w_ff  <= t_w_ff;
      end
   end

   // ---------------------------------------------------------------
   // Angle = -p in 2^-24 turn; top two bits pick the quadrant, the
   // rest drives the CORDIC.
   // ---------------------------------------------------------------
   logic [47:0] neg_p;

   logic signed [CORDIC_W-1:0] cd_x_ff    [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] cd_y_ff    [0:CORDIC_STEPS];
   logic signed [ANGLE_W-1:0]  cd_z_ff    [0:CORDIC_STEPS];
   logic [1:0]                 cd_quad_ff [0:CORDIC_STEPS];
   logic                       cd_in_ff   [0:CORDIC_STEPS];
   logic [2*TAPER_W-1:0]       cd_w_ff    [0:CORDIC_STEPS];

   assign neg_p = 48'd0 - p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_x_ff[0]    <= CORDIC_X0;
         cd_y_ff[0]    <= '0;
         cd_z_ff[0]    <= $signed({3'b000, neg_p[45:24]});
         cd_quad_ff[0] <= neg_p[47:46];
         cd_in_ff[0]   <= p_in_ff;
         cd_w_ff[0]    <= p_w_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CORDIC_W-1:0] dx, dy;
      logic signed [ANGLE_W-1:0]  da;

      assign dx = cd_y_ff[i] >>> i;
      assign dy = cd_x_ff[i] >>> i;
      assign da = $signed({3'b000, atan_entry(i)});

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cd_z_ff[i][ANGLE_W-1]) begin
               cd_x_ff[i+1] <= cd_x_ff[i] - dx;
               cd_y_ff[i+1] <= cd_y_ff[i] + dy;
               cd_z_ff[i+1] <= cd_z_ff[i] - da;
            end else begin
               cd_x_ff[i+1] <= cd_x_ff[i] + dx;
               cd_y_ff[i+1] <= cd_y_ff[i] - dy;
               cd_z_ff[i+1] <= cd_z_ff[i] + da;
            end
            cd_quad_ff[i+1] <= cd_quad_ff[i];
            cd_in_ff[i+1]   <= cd_in_ff[i];
            cd_w_ff[i+1]    <= cd_w_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Quadrant rotation
   // ---------------------------------------------------------------
   logic signed [CORDIC_W-1:0] cs_in, sn_in, cs_ff, sn_ff;
   logic                       q_in_ff;
   logic [2*TAPER_W-1:0]       q_w_ff;
   logic signed [CORDIC_W-1:0] xf, yf;

   assign xf = cd_x_ff[CORDIC_STEPS];
   assign yf = cd_y_ff[CORDIC_STEPS];

   always_comb begin
      case (cd_quad_ff[CORDIC_STEPS])
         2'd0: begin
            cs_in = xf;
            sn_in = yf;
         end
         2'd1: begin
            cs_in = -yf;
            sn_in = xf;
         end
         2'd2: begin
            cs_in = -xf;
            sn_in = -yf;
         end
         default: begin
            cs_in = yf;
            sn_in = -xf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_ff   <= cs_in;
         sn_ff   <= sn_in;
         q_in_ff <= cd_in_ff[CORDIC_STEPS];
         q_w_ff  <= cd_w_ff[CORDIC_STEPS];
      end
   end

   // ---------------------------------------------------------------
   // Taper scaling
   // ---------------------------------------------------------------
   localparam int PROD_W = 2 * TAPER_W + CORDIC_W + 1;

   logic signed [PROD_W-1:0] pr_in, pi_in, pr_ff, pi_ff;
   logic                     m_in_ff;

   assign pr_in = $signed({1'b0, q_w_ff}) * cs_ff;
   assign pi_in = $signed({1'b0, q_w_ff}) * sn_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff   <= pr_in;
         pi_ff   <= pi_in;
         m_in_ff <= q_in_ff;
      end
   end

   // ---------------------------------------------------------------
   // Round to Q1.15, saturate, zero outside the unit circle
   // ---------------------------------------------------------------
   localparam int RND_SHIFT = 45;
   localparam int RND_W     = PROD_W - RND_SHIFT;

   logic signed [PROD_W-1:0]   pr_rnd, pi_rnd;
   logic signed [RND_W-1:0]    re_sh, im_sh;
   logic signed [SAMPLE_W-1:0] re_in, im_in;
   logic signed [SAMPLE_W-1:0] re_ff, im_ff;
   logic                       inside_ff;

   assign pr_rnd = pr_ff + (PROD_W'(1) <<< (RND_SHIFT - 1));
   assign pi_rnd = pi_ff + (PROD_W'(1) <<< (RND_SHIFT - 1));
   assign re_sh  = pr_rnd[PROD_W-1:RND_SHIFT];
   assign im_sh  = pi_rnd[PROD_W-1:RND_SHIFT];

   always_comb begin
      if (re_sh > RND_W'(32767)) begin
         re_in = 16'sh7FFF;
      end else if (re_sh < -RND_W'(32768)) begin
         re_in = 16'sh8000;
      end else begin
         re_in = re_sh[SAMPLE_W-1:0];
      end
      if (im_sh > RND_W'(32767)) begin
         im_in = 16'sh7FFF;
      end else if (im_sh < -RND_W'(32768)) begin
         im_in = 16'sh8000;
      end else begin
         im_in = im_sh[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff     <= m_in_ff ? re_in : '0;
         im_ff     <= m_in_ff ? im_in : '0;
         inside_ff <= m_in_ff;
      end
   end

   assign rsp_real_part  = re_ff;
   assign rsp_imag_part  = im_ff;
   assign rsp_inside_res = inside_ff;

endmodule

### design/wpps_checker.sv
// Port-level checker for the phase screen, bound to the top level.
// Depends on wpps_pkg and w_projection_phase_screen_defines.svh.
`include "w_projection_phase_screen_defines.svh"

module wpps_checker
   import wpps_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_real_part,
   input logic signed [SAMPLE_W-1:0] rsp_imag_part,
   input logic                       rsp_inside_res
);

   // Outside pixels carry zero samples.
   `WPPS_ASSERT_IMPLY(a_outside_zero, clock, reset, rsp_valid && !rsp_inside_res, rsp_real_part == 16'sd0 && rsp_imag_part == 16'sd0)
   // Input backpressure only comes from a stalled result.
   `WPPS_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // A stalled result holds.
   `WPPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_real_part) && $stable(rsp_imag_part) && $stable(rsp_inside_res))
   // Nothing comes out right after reset.
   `WPPS_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid)

endmodule

bind w_projection_phase_screen wpps_checker u_wpps_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the W-projection phase screen.
// Depends on wpps_pkg and w_projection_phase_screen; predicts each sample in place unless a directed row fixes it.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wpps_pkg::*;

   localparam longint unsigned ONE_Q32     = 64'h1_0000_0000;
   localparam int              LATENCY     = 60;
   localparam int              CYCLE_LIMIT = 400000;
   localparam int              LONG_HOLD   = 400;

   typedef struct packed {
      logic [INDEX_W-1:0] col;
      logic [INDEX_W-1:0] row;
      logic [TAPER_W-1:0] taper_col;
      logic [TAPER_W-1:0] taper_row;
   } pixel_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       in_circle;
   } sample_type;

   // Directed stimulus row: a fixed expectation is used only where typed is set.
   typedef struct packed {
      pixel_type  px;
      logic       typed;
      sample_type exp;
   } vector_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]       csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [INDEX_W-1:0]     req_col_index = '0;
   logic [INDEX_W-1:0]     req_row_index = '0;
   logic [TAPER_W-1:0]     req_taper_col = '0;
   logic [TAPER_W-1:0]     req_taper_row = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   logic signed [SAMPLE_W-1:0] rsp_real_part;
   logic signed [SAMPLE_W-1:0] rsp_imag_part;
   logic                   rsp_inside_res;

   // Shadow copy of the block's registers.
   logic [31:0]        step_q = '0;
   logic [31:0]        turns_q = '0;
   logic [INDEX_W-1:0] half_q = HALF_SIZE_RESET;

   sample_type expected_samples[$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      calm = 0;          // no idling on either side while set
   bit      long_hold_req = 0; // ask the receiver for one long hold-off

   w_projection_phase_screen i_dut (.*);

   always #5 clock = ~clock;

   // arctan(2^-i) in units of 2^-24 turn
   longint arctan_turns[CORDIC_STEPS] = '{2097152, 1238021, 654136, 332050, 166669,
      83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] taper_scale(longint w, longint c);
      longint v;
      v = (w * c + (64'sd1 <<< 44)) >>> 45;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic sample_type predict_sample(pixel_type px);
      longint dc, dr, x, y, z, dx, dy, cs, sn, w;
      longint unsigned l, m, r2, s, q, t, p, a;
      logic [1:0] quad;
      sample_type o;
      o = '0;
      dc = longint'(px.col) - longint'(half_q);
      dr = longint'(px.row) - longint'(half_q);
      l = longint'(dc < 0 ? -dc : dc) * longint'({32'd0, step_q});
      m = longint'(dr < 0 ? -dr : dr) * longint'({32'd0, step_q});
      if (l >= ONE_Q32 || m >= ONE_Q32) return o;
      r2 = ((l * l) >> 32) + ((m * m) >> 32);
      if (r2 >= ONE_Q32) return o;
      s = ONE_Q32 - r2;
      q = (s == ONE_Q32) ? ONE_Q32 : int_sqrt(s << 32);
      t = ONE_Q32 - q;
      p = {32'd0, turns_q} * t;
      a = ((64'd0 - p) >> 24) & 64'hFF_FFFF;
      quad = a[23:22];
      z = longint'(a & 64'h3F_FFFF);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_turns[i];
         end else begin
            x += dx; y -= dy; z += arctan_turns[i];
         end
      end
      case (quad)
         2'd0:    begin cs = x;  sn = y;  end
         2'd1:    begin cs = -y; sn = x;  end
         2'd2:    begin cs = -x; sn = -y; end
         default: begin cs = y;  sn = -x; end
      endcase
      w = longint'(px.taper_col) * longint'(px.taper_row);
      o.re = taper_scale(w, cs);
      o.im = taper_scale(w, sn);
      o.in_circle = 1'b1;
      return o;
   endfunction

   // Mostly zero, sometimes a short gap, rarely a long gap.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return 0;
      if (r < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Check each accepted sample against the oldest expectation.
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("unexpected sample at cycle %0d", cycles);
            mismatches++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_real_part !== want.re) report_mismatch("real_part", rsp_real_part, want.re);
            if (rsp_imag_part !== want.im) report_mismatch("imag_part", rsp_imag_part, want.im);
            if (rsp_inside_res !== want.in_circle)
               report_mismatch("inside_res", rsp_inside_res, want.in_circle);
         end
      end
   end

   // Receiver: alternate stall and run stretches; serve one long hold-off on request.
   initial begin
      int run_left, hold_left;
      run_left = 0;
      hold_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            run_left = $urandom_range(0, 12);
            rsp_stall <= 1'b0;
         end else begin
            run_left = gap_len();
            rsp_stall <= (run_left > 0);
         end
         @(negedge clock);
      end
   end

   // Offer one transaction and hold it until accepted; record its expectation.
   task automatic send_pixel(pixel_type px, bit typed, sample_type fixed);
      int gap;
      req_valid     <= 1'b1;
      req_col_index <= px.col;
      req_row_index <= px.row;
      req_taper_col <= px.taper_col;
      req_taper_row <= px.taper_row;
      do @(posedge clock); while (req_stall);
      expected_samples.push_back(typed ? fixed : predict_sample(px));
      gap = calm ? 0 : gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Called at a falling edge; drop valid at once so nothing is offered twice.
   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_samples.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register while the block is idle; keep the shadow copy in step.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_PIXEL_STEP:  step_q = val;
         REG_PHASE_TURNS: turns_q = val;
         REG_HALF_SIZE:   half_q = val[INDEX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] st, logic [31:0] tu, logic [31:0] hs);
      write_reg(REG_PIXEL_STEP, st);
      write_reg(REG_PHASE_TURNS, tu);
      write_reg(REG_HALF_SIZE, hs);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      int span;
      // Mostly pixels around the centre so many land inside the circle.
      span = (half_q == 0) ? 1 : int'(half_q);
      if ($urandom_range(0, 3) != 0) begin
         px.col = INDEX_W'(int'(half_q) + $urandom_range(0, 2 * span) - span);
         px.row = INDEX_W'(int'(half_q) + $urandom_range(0, 2 * span) - span);
      end else begin
         px.col = INDEX_W'($urandom_range(0, 4095));
         px.row = INDEX_W'($urandom_range(0, 4095));
      end
      if ($urandom_range(0, 9) == 0) begin
         px.taper_col = TAPER_W'($urandom_range(0, 65535));
         px.taper_row = TAPER_W'($urandom_range(0, 65535));
      end else begin
         px.taper_col = TAPER_W'($urandom_range(0, 32768));
         px.taper_row = TAPER_W'($urandom_range(0, 32768));
      end
      return px;
   endfunction

   vector_type directed[20];

   initial begin
      logic [31:0] hs;
      // Rows 0..9 run with the reset registers, rows 10..19 with maximal step and scale.
      directed[0]  = '{'{12'd0, 12'd0, 16'd0, 16'd0}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};
      directed[1]  = '{'{12'd4095, 12'd4095, 16'd0, 16'd32768}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};
      directed[2]  = '{'{12'd2048, 12'd2048, 16'd32768, 16'd32768}, 1'b0, '0};
      directed[3]  = '{'{12'd0, 12'd4095, 16'd32768, 16'd32767}, 1'b0, '0};
      directed[4]  = '{'{12'd4095, 12'd0, 16'd65535, 16'd65535}, 1'b0, '0};
      directed[5]  = '{'{12'd1234, 12'd2987, 16'd16384, 16'd1}, 1'b0, '0};
      directed[6]  = '{'{12'd2047, 12'd2049, 16'd1, 16'd1}, 1'b0, '0};
      directed[7]  = '{'{12'd2730, 12'd1365, 16'd43690, 16'd21845}, 1'b0, '0};
      directed[8]  = '{'{12'd1365, 12'd2730, 16'd21845, 16'd43690}, 1'b0, '0};
      directed[9]  = '{'{12'd2048, 12'd0, 16'd32768, 16'd0}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};
      directed[10] = '{'{12'd0, 12'd0, 16'd32768, 16'd32768}, 1'b1, '{16'sd0, 16'sd0, 1'b0}};
      directed[11] = '{'{12'd4095, 12'd2048, 16'd32768, 16'd32768}, 1'b1, '{16'sd0, 16'sd0, 1'b0}};
      directed[12] = '{'{12'd2048, 12'd4095, 16'd65535, 16'd65535}, 1'b1, '{16'sd0, 16'sd0, 1'b0}};
      directed[13] = '{'{12'd2048, 12'd2048, 16'd32768, 16'd32768}, 1'b0, '0};
      directed[14] = '{'{12'd2048, 12'd2048, 16'd65535, 16'd65535}, 1'b0, '0};
      // One step off centre stays just inside the circle.
      directed[15] = '{'{12'd2049, 12'd2048, 16'd32768, 16'd32768}, 1'b0, '0};
      directed[16] = '{'{12'd2048, 12'd2047, 16'd32768, 16'd32768}, 1'b0, '0};
      directed[17] = '{'{12'd2048, 12'd2048, 16'd0, 16'd65535}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};
      directed[18] = '{'{12'd2048, 12'd2048, 16'd12345, 16'd30000}, 1'b0, '0};
      directed[19] = '{'{12'd2048, 12'd2048, 16'd1, 16'd32768}, 1'b0, '0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < 20; i++) begin
         if (i == 10) begin
            drain();
            // An unknown index must leave every register alone.
            write_reg(CSR_INDEX_W'(3), 32'hFFFF_FFFF);
            configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(HALF_SIZE_RESET));
         end
         send_pixel(directed[i].px, directed[i].typed, directed[i].exp);
      end

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: configure(32'd1, 32'hFFFF_FFFF, 32'd1);
            1: configure(32'hFFFF_FFFF, 32'd0, 32'd2048);
            2: configure(32'h0010_0000, 32'h0001_0000, 32'd2048);
            default: begin
               hs = $urandom_range(1, 2048);
               configure($urandom_range(0, 32'hFFFF_FFFF / hs), $urandom, hs);
            end
         endcase
         calm = (ph == 4);
         for (int n = 0; n < 100; n++) begin
            // Let the block fill up behind a long receiver hold-off.
            if (ph == 2 && n == 10) long_hold_req = 1;
            // Pause the sender until every sample has come back.
            if (ph == 3 && n == 50) begin
               req_valid <= 1'b0;
               wait (expected_samples.size() == 0);
               @(negedge clock);
            end
            send_pixel(random_pixel(), 1'b0, '0);
         end
      end
      calm = 0;

      drain();
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
